// ===== rtl/core/ehp_pkg.sv =====
// Shared types, constants and field helpers for the Ethernet/IP header parser.
// No dependencies; used by every module of the block.
package ehp_pkg;

   // Only the first 94 bytes of a frame are ever decoded
   localparam int KeepBytes  = 94;
   localparam int FrameBits  = KeepBytes * 8;
   localparam int IdxBits    = $clog2(KeepBytes);
   localparam int TpBytes    = 20;

   localparam logic [15:0] EtypeIpv4 = 16'h0800;
   localparam logic [15:0] EtypeIpv6 = 16'h86DD;
   localparam logic [15:0] EtypeArp  = 16'h0806;
   localparam logic [7:0]  ProtoTcp  = 8'd6;
   localparam logic [7:0]  ProtoUdp  = 8'd17;
   localparam logic [7:0]  ProtoIcmp = 8'd1;
   localparam logic [7:0]  ProtoIcmp6 = 8'd58;
   localparam logic [8:0]  TcpFlagMask = 9'h1FF;

   // Incomplete-header mask bits
   localparam int FlEth  = 0;
   localparam int FlArp  = 1;
   localparam int FlIpv4 = 2;
   localparam int FlIpv6 = 3;
   localparam int FlTcp  = 4;
   localparam int FlUdp  = 5;
   localparam int FlIcmp = 6;

   typedef enum logic [5:0] {
      FC_STATUS, FC_ETH_DST, FC_ETH_SRC, FC_ETH_TYPE,
      FC_ARP_HTYPE, FC_ARP_PTYPE, FC_ARP_HLEN, FC_ARP_PLEN, FC_ARP_OPER,
      FC_ARP_SHA, FC_ARP_SPA, FC_ARP_THA, FC_ARP_TPA,
      FC_IP4_HLEN, FC_IP4_TOS, FC_IP4_TLEN, FC_IP4_ID, FC_IP4_FRAG,
      FC_IP4_TTL, FC_IP4_PROTO, FC_IP4_CSUM, FC_IP4_SRC, FC_IP4_DST,
      FC_IP6_VCF, FC_IP6_PLEN, FC_IP6_NXT, FC_IP6_HOP,
      FC_IP6_SRC_HI, FC_IP6_SRC_LO, FC_IP6_DST_HI, FC_IP6_DST_LO,
      FC_TCP_SPORT, FC_TCP_DPORT, FC_TCP_SEQ, FC_TCP_ACK, FC_TCP_DOFF,
      FC_TCP_FLAGS, FC_TCP_WIN, FC_TCP_CSUM, FC_TCP_URG,
      FC_UDP_SPORT, FC_UDP_DPORT, FC_UDP_LEN, FC_UDP_CSUM,
      FC_ICMP_TYPE, FC_ICMP_CODE, FC_ICMP_CSUM, FC_ICMP_REST
   } field_code_type;

   // Frame hand-over from capture to emitter
   typedef struct packed {
      logic       load;
      logic [7:0] count;
   } load_type;

   // Big-endian read of len bytes starting at byte at
   function automatic logic [63:0] rd_be(input logic [FrameBits-1:0] v,
                                         input int at, input int len);
      logic [63:0] val;
      val = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < len) val = {val[55:0], v[(at + i) * 8 +: 8]};
      end
      return val;
   endfunction

endpackage

// ===== rtl/core/ethernet_ip_header_parser.sv =====
// Top level of the Ethernet/ARP/IPv4/IPv6/TCP/UDP/ICMP header parser.
// Depends on ehp_pkg, ehp_capture and ehp_emitter.
//
// Frame bytes enter one per cycle on the req stream, req_tlast on the final
// byte. The first 94 bytes are held in a capture register; at frame end they
// are copied to the emitter, which sends a status result and then each header
// field, one result per cycle unless rsp_tready is low, on the rsp stream with
// rsp_tlast on the final result of the frame. Bytes of the next frame are taken
// while a burst is being sent; only the final byte of a frame waits (req_tready
// low) until the emitter has finished the previous burst. The results of a
// frame overlap the following frame.
module ethernet_ip_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] field_value, [70:64] corrupt_flags, [71] zero
   output logic [5:0]  rsp_tuser,   // [5:0] field_code
   output logic        rsp_tlast
);

   ehp_pkg::load_type             load;
   logic [ehp_pkg::FrameBits-1:0] frame;
   logic        busy, accept;
   logic [63:0] value;
   logic [6:0]  flags;

   // Stall only the final byte while a burst is in flight
   assign req_tready = !busy || !req_tlast;
   assign accept     = req_tvalid && req_tready;

   ehp_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_frame (req_tlast),
      .load         (load),
      .frame        (frame)
   );

   ehp_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .frame     (frame),
      .busy      (busy),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_code  (rsp_tuser),
      .rsp_value (value),
      .rsp_flags (flags),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, flags, value};

endmodule

// ===== rtl/core/ehp_capture.sv =====
// Byte counter and header capture register for the header parser.
// Depends on ehp_pkg.
module ehp_capture (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          end_of_frame,
   output ehp_pkg::load_type             load,
   output logic [ehp_pkg::FrameBits-1:0] frame
);

   logic [ehp_pkg::FrameBits-1:0] cap_ff, cap_in;
   logic [7:0] count_ff, count_in, count_inc;

   // Saturating byte count
   assign count_inc = (count_ff != 8'hFF) ? count_ff + 8'd1 : count_ff;

   // Store the byte at its frame position
   always_comb begin
      cap_in = cap_ff;
      if (accept && (count_ff < 8'(ehp_pkg::KeepBytes))) begin
         cap_in[count_ff[ehp_pkg::IdxBits-1:0] * 8 +: 8] = data_byte;
      end
   end

   // Restart the count after the final byte
   always_comb begin
      count_in = count_ff;
      if (accept) count_in = end_of_frame ? 8'd0 : count_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

   assign load.load  = accept && end_of_frame;
   assign load.count = count_inc;
   assign frame      = cap_in;

endmodule

// ===== rtl/core/ehp_emitter.sv =====
// Frame snapshot, header decode and result sequencer with output register.
// Depends on ehp_pkg.
module ehp_emitter (
   input  logic                          clock,
   input  logic                          reset,
   input  ehp_pkg::load_type             load,
   input  logic [ehp_pkg::FrameBits-1:0] frame,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [5:0]                    rsp_code,
   output logic [63:0]                   rsp_value,
   output logic [6:0]                    rsp_flags,
   output logic                          rsp_last
);

   logic [ehp_pkg::FrameBits-1:0] frame_ff;
   logic [7:0]  n_ff;
   logic        busy_ff, busy_in;
   ehp_pkg::field_code_type code_ff, code_in, nxt;
   logic        is_last, advance;

   logic        valid_ff, valid_in;
   logic [5:0]  ocode_ff;
   logic [63:0] oval_ff;
   logic [6:0]  oflag_ff;
   logic        olast_ff;

   logic [15:0] etype;
   logic [3:0]  ihl;
   logic [5:0]  hl;
   logic [7:0]  proto, base;
   logic [2:0]  lstage;
   logic        v6, is_tcp, is_udp, is_icmp, tp_on;
   logic [6:0]  mask;
   logic [ehp_pkg::FrameBits-1:0] tb;
   logic [63:0] value, tcpw;

   // Decode the header layers of the held frame
   always_comb begin
      etype  = {frame_ff[12*8 +: 8], frame_ff[13*8 +: 8]};
      ihl    = frame_ff[14*8 +: 4];
      hl     = {ihl, 2'b00};
      mask   = '0;
      lstage = 3'd0;
      v6     = 1'b0;
      proto  = 8'd0;
      base   = 8'd54;
      if (n_ff < 8'd14) begin
         mask[ehp_pkg::FlEth] = 1'b1;
      end else begin
         lstage = 3'd1;
         if (etype == ehp_pkg::EtypeArp) begin
            if (n_ff < 8'd42) mask[ehp_pkg::FlArp] = 1'b1;
            else lstage = 3'd2;
         end else if (etype == ehp_pkg::EtypeIpv4) begin
            if (n_ff < 8'd34 || hl < 6'd20 || n_ff < 8'd14 + {2'b00, hl}) begin
               mask[ehp_pkg::FlIpv4] = 1'b1;
            end else begin
               lstage = 3'd3;
               proto  = frame_ff[23*8 +: 8];
               base   = 8'd14 + {2'b00, hl};
            end
         end else if (etype == ehp_pkg::EtypeIpv6) begin
            if (n_ff < 8'd54) begin
               mask[ehp_pkg::FlIpv6] = 1'b1;
            end else begin
               lstage = 3'd4;
               v6     = 1'b1;
               proto  = frame_ff[20*8 +: 8];
            end
         end
      end
      is_tcp  = (lstage >= 3'd3) && (proto == ehp_pkg::ProtoTcp);
      is_udp  = (lstage >= 3'd3) && (proto == ehp_pkg::ProtoUdp);
      is_icmp = (lstage >= 3'd3) &&
                (proto == (v6 ? ehp_pkg::ProtoIcmp6 : ehp_pkg::ProtoIcmp));
      if (is_tcp && ({1'b0, n_ff} < {1'b0, base} + 9'd20)) mask[ehp_pkg::FlTcp] = 1'b1;
      if (is_udp && ({1'b0, n_ff} < {1'b0, base} + 9'd8)) mask[ehp_pkg::FlUdp] = 1'b1;
      if (is_icmp && ({1'b0, n_ff} < {1'b0, base} + 9'd8)) mask[ehp_pkg::FlIcmp] = 1'b1;
      tp_on = (is_tcp || is_udp || is_icmp) && (mask[6:4] == 3'b000);
   end

   // Select the transport header window
   always_comb begin
      tb = '0;
      if (v6) begin
         tb[ehp_pkg::TpBytes*8-1:0] = frame_ff[54*8 +: ehp_pkg::TpBytes*8];
      end else begin
         for (int k = 5; k < 16; k++) begin
            if (ihl == 4'(k)) begin
               tb[ehp_pkg::TpBytes*8-1:0] = frame_ff[(14 + 4*k)*8 +: ehp_pkg::TpBytes*8];
            end
         end
      end
   end

   // Field value for the current code
   always_comb begin
      tcpw = ehp_pkg::rd_be(tb, 12, 2);
      unique case (code_ff)
         ehp_pkg::FC_STATUS:     value = {57'd0, mask};
         ehp_pkg::FC_ETH_DST:    value = ehp_pkg::rd_be(frame_ff, 0, 6);
         ehp_pkg::FC_ETH_SRC:    value = ehp_pkg::rd_be(frame_ff, 6, 6);
         ehp_pkg::FC_ETH_TYPE:   value = {48'd0, etype};
         ehp_pkg::FC_ARP_HTYPE:  value = ehp_pkg::rd_be(frame_ff, 14, 2);
         ehp_pkg::FC_ARP_PTYPE:  value = ehp_pkg::rd_be(frame_ff, 16, 2);
         ehp_pkg::FC_ARP_HLEN:   value = ehp_pkg::rd_be(frame_ff, 18, 1);
         ehp_pkg::FC_ARP_PLEN:   value = ehp_pkg::rd_be(frame_ff, 19, 1);
         ehp_pkg::FC_ARP_OPER:   value = ehp_pkg::rd_be(frame_ff, 20, 2);
         ehp_pkg::FC_ARP_SHA:    value = ehp_pkg::rd_be(frame_ff, 22, 6);
         ehp_pkg::FC_ARP_SPA:    value = ehp_pkg::rd_be(frame_ff, 28, 4);
         ehp_pkg::FC_ARP_THA:    value = ehp_pkg::rd_be(frame_ff, 32, 6);
         ehp_pkg::FC_ARP_TPA:    value = ehp_pkg::rd_be(frame_ff, 38, 4);
         ehp_pkg::FC_IP4_HLEN:   value = {58'd0, hl};
         ehp_pkg::FC_IP4_TOS:    value = ehp_pkg::rd_be(frame_ff, 15, 1);
         ehp_pkg::FC_IP4_TLEN:   value = ehp_pkg::rd_be(frame_ff, 16, 2);
         ehp_pkg::FC_IP4_ID:     value = ehp_pkg::rd_be(frame_ff, 18, 2);
         ehp_pkg::FC_IP4_FRAG:   value = ehp_pkg::rd_be(frame_ff, 20, 2);
         ehp_pkg::FC_IP4_TTL:    value = ehp_pkg::rd_be(frame_ff, 22, 1);
         ehp_pkg::FC_IP4_PROTO:  value = ehp_pkg::rd_be(frame_ff, 23, 1);
         ehp_pkg::FC_IP4_CSUM:   value = ehp_pkg::rd_be(frame_ff, 24, 2);
         ehp_pkg::FC_IP4_SRC:    value = ehp_pkg::rd_be(frame_ff, 26, 4);
         ehp_pkg::FC_IP4_DST:    value = ehp_pkg::rd_be(frame_ff, 30, 4);
         ehp_pkg::FC_IP6_VCF:    value = ehp_pkg::rd_be(frame_ff, 14, 4);
         ehp_pkg::FC_IP6_PLEN:   value = ehp_pkg::rd_be(frame_ff, 18, 2);
         ehp_pkg::FC_IP6_NXT:    value = ehp_pkg::rd_be(frame_ff, 20, 1);
         ehp_pkg::FC_IP6_HOP:    value = ehp_pkg::rd_be(frame_ff, 21, 1);
         ehp_pkg::FC_IP6_SRC_HI: value = ehp_pkg::rd_be(frame_ff, 22, 8);
         ehp_pkg::FC_IP6_SRC_LO: value = ehp_pkg::rd_be(frame_ff, 30, 8);
         ehp_pkg::FC_IP6_DST_HI: value = ehp_pkg::rd_be(frame_ff, 38, 8);
         ehp_pkg::FC_IP6_DST_LO: value = ehp_pkg::rd_be(frame_ff, 46, 8);
         ehp_pkg::FC_TCP_SPORT:  value = ehp_pkg::rd_be(tb, 0, 2);
         ehp_pkg::FC_TCP_DPORT:  value = ehp_pkg::rd_be(tb, 2, 2);
         ehp_pkg::FC_TCP_SEQ:    value = ehp_pkg::rd_be(tb, 4, 4);
         ehp_pkg::FC_TCP_ACK:    value = ehp_pkg::rd_be(tb, 8, 4);
         ehp_pkg::FC_TCP_DOFF:   value = {58'd0, tcpw[15:12], 2'b00};
         ehp_pkg::FC_TCP_FLAGS:  value = {55'd0, tcpw[8:0] & ehp_pkg::TcpFlagMask};
         ehp_pkg::FC_TCP_WIN:    value = ehp_pkg::rd_be(tb, 14, 2);
         ehp_pkg::FC_TCP_CSUM:   value = ehp_pkg::rd_be(tb, 16, 2);
         ehp_pkg::FC_TCP_URG:    value = ehp_pkg::rd_be(tb, 18, 2);
         ehp_pkg::FC_UDP_SPORT:  value = ehp_pkg::rd_be(tb, 0, 2);
         ehp_pkg::FC_UDP_DPORT:  value = ehp_pkg::rd_be(tb, 2, 2);
         ehp_pkg::FC_UDP_LEN:    value = ehp_pkg::rd_be(tb, 4, 2);
         ehp_pkg::FC_UDP_CSUM:   value = ehp_pkg::rd_be(tb, 6, 2);
         ehp_pkg::FC_ICMP_TYPE:  value = ehp_pkg::rd_be(tb, 0, 1);
         ehp_pkg::FC_ICMP_CODE:  value = ehp_pkg::rd_be(tb, 1, 1);
         ehp_pkg::FC_ICMP_CSUM:  value = ehp_pkg::rd_be(tb, 2, 2);
         ehp_pkg::FC_ICMP_REST:  value = ehp_pkg::rd_be(tb, 4, 4);
         default:                value = '0;
      endcase
   end

   // Pick the next field to emit, or mark the last one
   always_comb begin
      is_last = 1'b0;
      nxt     = ehp_pkg::field_code_type'(code_ff + 6'd1);
      unique case (code_ff)
         ehp_pkg::FC_STATUS:   is_last = (lstage == 3'd0);
         ehp_pkg::FC_ETH_TYPE: begin
            if (lstage == 3'd2) nxt = ehp_pkg::FC_ARP_HTYPE;
            else if (lstage == 3'd3) nxt = ehp_pkg::FC_IP4_HLEN;
            else if (lstage == 3'd4) nxt = ehp_pkg::FC_IP6_VCF;
            else is_last = 1'b1;
         end
         ehp_pkg::FC_IP4_DST, ehp_pkg::FC_IP6_DST_LO: begin
            if (!tp_on) is_last = 1'b1;
            else if (is_tcp) nxt = ehp_pkg::FC_TCP_SPORT;
            else if (is_udp) nxt = ehp_pkg::FC_UDP_SPORT;
            else nxt = ehp_pkg::FC_ICMP_TYPE;
         end
         ehp_pkg::FC_ARP_TPA, ehp_pkg::FC_TCP_URG, ehp_pkg::FC_UDP_CSUM,
         ehp_pkg::FC_ICMP_REST: is_last = 1'b1;
         default: ;
      endcase
   end

   // Advance when the output register is free
   assign advance = busy_ff && (!valid_ff || rsp_ready);

   always_comb begin
      busy_in  = busy_ff;
      code_in  = code_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load.load) begin
         busy_in = 1'b1;
         code_in = ehp_pkg::FC_STATUS;
      end else if (advance) begin
         valid_in = 1'b1;
         code_in  = nxt;
         if (is_last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         code_ff  <= ehp_pkg::FC_STATUS;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         code_ff  <= code_in;
      end
   end

   // Hold the frame and load results
   always_ff @(posedge clock) begin
      if (load.load) begin
         frame_ff <= frame;
         n_ff     <= load.count;
      end
      if (advance) begin
         ocode_ff <= code_ff;
         oval_ff  <= value;
         oflag_ff <= mask;
         olast_ff <= is_last;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_code  = ocode_ff;
   assign rsp_value = oval_ff;
   assign rsp_flags = oflag_ff;
   assign rsp_last  = olast_ff;

endmodule

// ===== rtl/core/ehp_checker.sv =====
// Port-level checks for the header parser, bound to the top level.
// Depends on ehp_pkg and the ethernet_ip_header_parser ports.
module ehp_assert (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [5:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // No result right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Status value equals its flag mask
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ehp_pkg::FC_STATUS |->
         rsp_tdata[63:7] == 57'd0 && rsp_tdata[6:0] == rsp_tdata[70:64])
      else $error("status value mismatch");

   // Short frame gives status only
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ehp_pkg::FC_STATUS && rsp_tdata[64 + ehp_pkg::FlEth]
         |-> rsp_tlast)
      else $error("short frame emitted fields");

   // Only a final byte is ever held off
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tlast |-> req_tready)
      else $error("mid-frame byte stalled");

endmodule

bind ethernet_ip_header_parser ehp_assert u_ehp_assert (.*);

// ===== bench/ehp_checker.sv =====
// Response checker for the Ethernet/IP header parser: watches both streams,
// predicts the header field burst of each frame and compares. Depends on ehp_pkg.
`timescale 1ns / 1ps
module ehp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [5:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          fields_pending
);

   typedef struct {
      ehp_pkg::field_code_type code;
      logic [63:0]             value;
      logic [6:0]              flags;
      logic                    last;
   } field_rec_type;

   logic [7:0]    frame_bytes [0:127];
   int            frame_len;
   field_rec_type field_queue [$];

   function automatic logic [63:0] be_read(int at, int len);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < len; i++)
         v = {v[55:0], (at + i < 128) ? frame_bytes[at + i] : 8'h00};
      return v;
   endfunction

   task automatic push_field(ehp_pkg::field_code_type code, logic [63:0] value,
                             logic [6:0] flags);
      field_rec_type r;
      r.code  = code;
      r.value = value;
      r.flags = flags;
      r.last  = 1'b0;
      field_queue.push_back(r);
   endtask

   // Predict the whole burst for the frame just closed
   task automatic predict_headers(int n);
      logic [6:0]    mask;
      logic [15:0]   etype;
      logic [7:0]    proto;
      int            hl, tb, layer, kind;
      logic [15:0]   tcp_word;
      field_rec_type r;
      mask = '0; layer = 0; kind = 3; hl = 0; tb = 0; etype = '0; proto = '0;
      if (n < 14) begin
         mask[ehp_pkg::FlEth] = 1'b1;
      end else begin
         layer = 1;
         etype = 16'(be_read(12, 2));
         if (etype == ehp_pkg::EtypeArp) begin
            if (n < 42) mask[ehp_pkg::FlArp] = 1'b1; else layer = 2;
         end else if (etype == ehp_pkg::EtypeIpv4) begin
            hl = (frame_bytes[14] & 8'h0F) * 4;
            if (n < 34 || hl < 20 || n < 14 + hl) mask[ehp_pkg::FlIpv4] = 1'b1;
            else begin
               layer = 3; tb = 14 + hl; proto = frame_bytes[23];
               kind = proto == ehp_pkg::ProtoTcp ? 0 : proto == ehp_pkg::ProtoUdp ? 1 :
                      proto == ehp_pkg::ProtoIcmp ? 2 : 3;
            end
         end else if (etype == ehp_pkg::EtypeIpv6) begin
            if (n < 54) mask[ehp_pkg::FlIpv6] = 1'b1;
            else begin
               layer = 4; tb = 54; proto = frame_bytes[20];
               kind = proto == ehp_pkg::ProtoTcp ? 0 : proto == ehp_pkg::ProtoUdp ? 1 :
                      proto == ehp_pkg::ProtoIcmp6 ? 2 : 3;
            end
         end
      end
      // transport completeness
      if (kind == 0 && n < tb + 20) begin mask[ehp_pkg::FlTcp] = 1'b1; kind = 3; end
      if (kind == 1 && n < tb + 8)  begin mask[ehp_pkg::FlUdp] = 1'b1; kind = 3; end
      if (kind == 2 && n < tb + 8)  begin mask[ehp_pkg::FlIcmp] = 1'b1; kind = 3; end

      push_field(ehp_pkg::FC_STATUS, 64'(mask), mask);
      if (layer >= 1) begin
         push_field(ehp_pkg::FC_ETH_DST, be_read(0, 6), mask);
         push_field(ehp_pkg::FC_ETH_SRC, be_read(6, 6), mask);
         push_field(ehp_pkg::FC_ETH_TYPE, 64'(etype), mask);
      end
      if (layer == 2) begin
         push_field(ehp_pkg::FC_ARP_HTYPE, be_read(14, 2), mask);
         push_field(ehp_pkg::FC_ARP_PTYPE, be_read(16, 2), mask);
         push_field(ehp_pkg::FC_ARP_HLEN, be_read(18, 1), mask);
         push_field(ehp_pkg::FC_ARP_PLEN, be_read(19, 1), mask);
         push_field(ehp_pkg::FC_ARP_OPER, be_read(20, 2), mask);
         push_field(ehp_pkg::FC_ARP_SHA, be_read(22, 6), mask);
         push_field(ehp_pkg::FC_ARP_SPA, be_read(28, 4), mask);
         push_field(ehp_pkg::FC_ARP_THA, be_read(32, 6), mask);
         push_field(ehp_pkg::FC_ARP_TPA, be_read(38, 4), mask);
      end else if (layer == 3) begin
         push_field(ehp_pkg::FC_IP4_HLEN, 64'(hl), mask);
         push_field(ehp_pkg::FC_IP4_TOS, be_read(15, 1), mask);
         push_field(ehp_pkg::FC_IP4_TLEN, be_read(16, 2), mask);
         push_field(ehp_pkg::FC_IP4_ID, be_read(18, 2), mask);
         push_field(ehp_pkg::FC_IP4_FRAG, be_read(20, 2), mask);
         push_field(ehp_pkg::FC_IP4_TTL, be_read(22, 1), mask);
         push_field(ehp_pkg::FC_IP4_PROTO, be_read(23, 1), mask);
         push_field(ehp_pkg::FC_IP4_CSUM, be_read(24, 2), mask);
         push_field(ehp_pkg::FC_IP4_SRC, be_read(26, 4), mask);
         push_field(ehp_pkg::FC_IP4_DST, be_read(30, 4), mask);
      end else if (layer == 4) begin
         push_field(ehp_pkg::FC_IP6_VCF, be_read(14, 4), mask);
         push_field(ehp_pkg::FC_IP6_PLEN, be_read(18, 2), mask);
         push_field(ehp_pkg::FC_IP6_NXT, be_read(20, 1), mask);
         push_field(ehp_pkg::FC_IP6_HOP, be_read(21, 1), mask);
         push_field(ehp_pkg::FC_IP6_SRC_HI, be_read(22, 8), mask);
         push_field(ehp_pkg::FC_IP6_SRC_LO, be_read(30, 8), mask);
         push_field(ehp_pkg::FC_IP6_DST_HI, be_read(38, 8), mask);
         push_field(ehp_pkg::FC_IP6_DST_LO, be_read(46, 8), mask);
      end
      if (layer >= 3) begin
         if (kind == 0) begin
            tcp_word = 16'(be_read(tb + 12, 2));
            push_field(ehp_pkg::FC_TCP_SPORT, be_read(tb, 2), mask);
            push_field(ehp_pkg::FC_TCP_DPORT, be_read(tb + 2, 2), mask);
            push_field(ehp_pkg::FC_TCP_SEQ, be_read(tb + 4, 4), mask);
            push_field(ehp_pkg::FC_TCP_ACK, be_read(tb + 8, 4), mask);
            push_field(ehp_pkg::FC_TCP_DOFF, 64'(tcp_word[15:12]) * 4, mask);
            push_field(ehp_pkg::FC_TCP_FLAGS,
                       64'(tcp_word[8:0] & ehp_pkg::TcpFlagMask), mask);
            push_field(ehp_pkg::FC_TCP_WIN, be_read(tb + 14, 2), mask);
            push_field(ehp_pkg::FC_TCP_CSUM, be_read(tb + 16, 2), mask);
            push_field(ehp_pkg::FC_TCP_URG, be_read(tb + 18, 2), mask);
         end else if (kind == 1) begin
            push_field(ehp_pkg::FC_UDP_SPORT, be_read(tb, 2), mask);
            push_field(ehp_pkg::FC_UDP_DPORT, be_read(tb + 2, 2), mask);
            push_field(ehp_pkg::FC_UDP_LEN, be_read(tb + 4, 2), mask);
            push_field(ehp_pkg::FC_UDP_CSUM, be_read(tb + 6, 2), mask);
         end else if (kind == 2) begin
            push_field(ehp_pkg::FC_ICMP_TYPE, be_read(tb, 1), mask);
            push_field(ehp_pkg::FC_ICMP_CODE, be_read(tb + 1, 1), mask);
            push_field(ehp_pkg::FC_ICMP_CSUM, be_read(tb + 2, 2), mask);
            push_field(ehp_pkg::FC_ICMP_REST, be_read(tb + 4, 4), mask);
         end
      end
      r = field_queue[$];
      r.last = 1'b1;
      field_queue[$] = r;
   endtask

   always @(posedge clock) begin
      field_rec_type exp_f;
      if (reset) begin
         frame_len      <= 0;
         fail_count     <= 0;
         fields_pending <= 0;
      end else begin
         // capture input bytes, count saturates at 255
         if (req_tvalid && req_tready) begin
            int n;
            n = frame_len;
            if (n < 255) begin
               if (n < 128) frame_bytes[n] = req_tdata;
               n++;
            end
            if (req_tlast) begin
               predict_headers(n);
               n = 0;
            end
            frame_len <= n;
         end
         // compare each result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (field_queue.size() == 0) begin
               $error("unexpected result code=%0d value=%h", rsp_tuser, rsp_tdata[63:0]);
               fail_count <= fail_count + 1;
            end else begin
               exp_f = field_queue.pop_front();
               if (rsp_tuser !== exp_f.code || rsp_tdata[63:0] !== exp_f.value ||
                   rsp_tdata[70:64] !== exp_f.flags || rsp_tdata[71] !== 1'b0 ||
                   rsp_tlast !== exp_f.last) begin
                  if (rsp_tuser !== exp_f.code)
                     $error("field_code expected %0d actual %0d", exp_f.code, rsp_tuser);
                  if (rsp_tdata[63:0] !== exp_f.value)
                     $error("field_value expected %h actual %h", exp_f.value,
                            rsp_tdata[63:0]);
                  if (rsp_tdata[70:64] !== exp_f.flags)
                     $error("corrupt_flags expected %h actual %h", exp_f.flags,
                            rsp_tdata[70:64]);
                  if (rsp_tdata[71] !== 1'b0)
                     $error("tdata pad expected 0 actual %b", rsp_tdata[71]);
                  if (rsp_tlast !== exp_f.last)
                     $error("last_result expected %b actual %b", exp_f.last, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         fields_pending <= field_queue.size();
      end
   end

endmodule

// ===== bench/ethernet_ip_header_parser_test.sv =====
// Top of the header parser bench: clock, reset, frame stimulus and verdict.
// Depends on ehp_pkg, ethernet_ip_header_parser and ehp_checker.
`timescale 1ns / 1ps
module ethernet_ip_header_parser_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          fields_pending;
   int          items_sent;
   bit          quiet_phase = 1'b0;
   bit          hold_rsp = 1'b0;
   logic [7:0]  frame_buf [0:299];

   always #5 clock = ~clock;

   ethernet_ip_header_parser dut (.*);

   ehp_checker checker_i (.*);

   // Fill frame_buf with a frame of given type; random content elsewhere
   task automatic build_frame(int kind_sel, int len, int ihl, int proto_sel);
      logic [15:0] et;
      for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom);
      case (kind_sel)
         0: et = ehp_pkg::EtypeArp;
         1: et = ehp_pkg::EtypeIpv4;
         2: et = ehp_pkg::EtypeIpv6;
         default: et = 16'($urandom);
      endcase
      if (len > 13) begin frame_buf[12] = et[15:8]; frame_buf[13] = et[7:0]; end
      if (kind_sel == 1 && len > 14) frame_buf[14] = {4'h4, 4'(ihl)};
      if (len > 23) begin
         case (proto_sel)
            0: frame_buf[kind_sel == 2 ? 20 : 23] = ehp_pkg::ProtoTcp;
            1: frame_buf[kind_sel == 2 ? 20 : 23] = ehp_pkg::ProtoUdp;
            2: frame_buf[kind_sel == 2 ? 20 : 23] =
                  kind_sel == 2 ? ehp_pkg::ProtoIcmp6 : ehp_pkg::ProtoIcmp;
            default: ;
         endcase
      end
   endtask

   // Send len bytes, random gaps unless in the quiet phase
   task automatic send_frame(int len);
      for (int i = 0; i < len; i++) begin
         if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= frame_buf[i];
         req_tlast  <= (i == len - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         items_sent++;
      end
   endtask

   // Drop the request before waiting on results
   task automatic idle_input();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_frame(int max_len);
      int k, len, ihl, p;
      k = $urandom_range(0, 3);
      p = $urandom_range(0, 3);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 10);
      case ($urandom_range(0, 9))
         0: len = $urandom_range(1, 20);
         1: len = $urandom_range(21, 60);
         2: len = $urandom_range(130, 280);
         default: len = $urandom_range(60, 100);
      endcase
      if (len > max_len) len = max_len;
      build_frame(k, len, ihl, p);
      send_frame(len);
   endtask

   // Receiver: random stall bursts, one long hold, none in the quiet phase
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int idle;
      items_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: short frame, unknown type, ARP, IPv4 with TCP
      build_frame(3, 1, 5, 3);  send_frame(1);
      build_frame(3, 14, 5, 3); send_frame(14);
      build_frame(0, 42, 5, 3); send_frame(42);
      build_frame(1, 54, 5, 0); send_frame(54);
      // pause until every prediction has been matched
      idle_input();
      while (fields_pending != 0) @(posedge clock);
      // long receiver hold while frames keep coming
      hold_rsp = 1'b1;
      build_frame(1, 42, 5, 1); send_frame(42);
      build_frame(1, 20, 5, 3); send_frame(20);
      while (items_sent < 200) begin
         if (items_sent >= 170) quiet_phase = 1'b1;
         random_frame(210 - items_sent);
      end
      idle_input();
      idle = 0;
      while (fields_pending != 0 && idle < 100000) begin
         @(posedge clock);
         idle++;
      end
      repeat (30) @(posedge clock);
      if (fail_count == 0 && fields_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
